// ----- design/lcdw_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the LCD decimal field writer.
package lcdw_pkg;

    localparam int DISPLAY_COLUMNS_DEF = 16;
    localparam int VALUE_BITS_DEF      = 32;
    localparam int MAX_DIGITS          = 10;
    localparam int ND_W                = $clog2(MAX_DIGITS + 1);
    localparam int WIDTH_LIMIT         = 16;
    localparam int OFF_W               = 6;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [1:0] MODE_RIGHT = 2'd0;
    localparam logic [1:0] MODE_ZERO  = 2'd1;
    localparam logic [1:0] MODE_LEFT  = 2'd2;

    localparam logic [7:0] ADDR_CMD   = 8'h80;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] SPACE_CHAR = 8'h20;

    // floor(v / 10) == (v * RECIP_TEN) >> RECIP_SHIFT for every 32-bit v
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic                          left_align;
        logic                          row_ok;
        logic [6:0]                    base;
        logic [OFF_W-1:0]              off;
        logic [ND_W-1:0]               num_digits;
        logic [4:0]                    num_pad;
        digit_t [MAX_DIGITS-1:0]       digits;
    } desc_t;

    function automatic logic [6:0] row_base(input logic [1:0] idx);
        logic [6:0] b;
        case (idx)
            2'd0:    b = 7'h00;
            2'd1:    b = 7'h40;
            2'd2:    b = 7'h10;
            default: b = 7'h50;
        endcase
        return b;
    endfunction

endpackage

// ----- design/lcdw_in_if.sv -----
`timescale 1ns / 1ps
// Request channel: one number with its placement per transaction.
interface lcdw_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] value;
    logic [4:0]  column;
    logic [2:0]  row;
    logic [4:0]  field_width;

    modport source (output valid, output mode, output value, output column, output row,
                    output field_width, input ready);
    modport sink   (input valid, input mode, input value, input column, input row,
                    input field_width, output ready);
endinterface

// ----- design/lcdw_out_if.sv -----
`timescale 1ns / 1ps
// LCD write channel: one instruction or data byte per transaction.
interface lcdw_out_if;
    logic       valid;
    logic       ready;
    logic       reg_select;
    logic [7:0] lcd_byte;
    logic       last;

    modport source (output valid, output reg_select, output lcd_byte, output last,
                    input ready);
    modport sink   (input valid, input reg_select, input lcd_byte, input last,
                    output ready);
endinterface

// ----- design/lcdw_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts a request, extracts decimal digits, builds a write descriptor.
module lcdw_front #(
    parameter int VALUE_BITS      = lcdw_pkg::VALUE_BITS_DEF,
    parameter int DISPLAY_COLUMNS = lcdw_pkg::DISPLAY_COLUMNS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    lcdw_in_if.sink         request,
    output logic            push,
    output lcdw_pkg::desc_t push_desc,
    input  logic            full
);

    localparam int PROD_W     = VALUE_BITS + 32;
    localparam int MAX_START  = 31 + lcdw_pkg::WIDTH_LIMIT - 2;
    localparam int WRAP_STEPS = MAX_START / DISPLAY_COLUMNS;
    localparam logic [7:0] COLS8 = 8'(DISPLAY_COLUMNS);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_PUSH} state_t;

    state_t                                  state_reg;
    logic [lcdw_pkg::ND_W-1:0]               nd_reg;
    logic [1:0]                              mode_reg;
    logic [4:0]                              column_reg;
    logic [2:0]                              row_reg;
    logic [4:0]                              width_reg;
    logic [VALUE_BITS-1:0]                   v_reg;
    logic [PROD_W-1:0]                       prod_reg;
    lcdw_pkg::digit_t [lcdw_pkg::MAX_DIGITS-1:0] digits_reg;

    logic [PROD_W-1:0]       q_wide;
    logic [VALUE_BITS-1:0]   q;
    logic [VALUE_BITS+3:0]   q_times_ten;
    logic [VALUE_BITS+3:0]   rem_wide;
    logic                    accept;
    logic                    mode_ok;
    logic signed [7:0]       col_s;
    logic signed [7:0]       wid_s;
    logic signed [7:0]       start_m1;
    logic [7:0]              start_wrap;

    function automatic logic [7:0] wrap_cols(input logic signed [7:0] x);
        logic [7:0] y;
        y = x;
        if (x < 0)
            y = y + COLS8;
        for (int i = 0; i < WRAP_STEPS; i++)
        begin
            if (y >= COLS8)
                y = y - COLS8;
        end
        return y;
    endfunction

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign mode_ok       = (request.mode == lcdw_pkg::MODE_RIGHT) ||
                           (request.mode == lcdw_pkg::MODE_ZERO)  ||
                           (request.mode == lcdw_pkg::MODE_LEFT);

    assign q_wide      = prod_reg >> lcdw_pkg::RECIP_SHIFT;
    assign q           = q_wide[VALUE_BITS-1:0];
    assign q_times_ten = ({4'b0, q} << 3) + ({4'b0, q} << 1);
    assign rem_wide    = {4'b0, v_reg} - q_times_ten;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nd_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && mode_ok)
                    begin
                        state_reg <= S_MUL;
                        nd_reg    <= '0;
                    end
                end
                S_MUL:
                    state_reg <= S_DIV;
                S_DIV:
                begin
                    nd_reg <= nd_reg + 1'b1;
                    if (q == '0 || nd_reg == lcdw_pkg::ND_W'(lcdw_pkg::MAX_DIGITS - 1))
                        state_reg <= S_PUSH;
                    else
                        state_reg <= S_MUL;
                end
                S_PUSH:
                begin
                    if (!full)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= request.mode;
            column_reg <= request.column;
            row_reg    <= request.row;
            width_reg  <= (request.field_width > 5'(lcdw_pkg::WIDTH_LIMIT)) ?
                          5'(lcdw_pkg::WIDTH_LIMIT) : request.field_width;
            v_reg      <= request.value[VALUE_BITS-1:0];
        end
        else if (state_reg == S_MUL)
            prod_reg <= PROD_W'(v_reg) * PROD_W'(lcdw_pkg::RECIP_TEN);
        else if (state_reg == S_DIV)
        begin
            digits_reg[nd_reg] <= rem_wide[3:0];
            v_reg              <= q;
        end
    end

    // descriptor
    assign col_s      = signed'({3'b0, column_reg});
    assign wid_s      = signed'({3'b0, width_reg});
    assign start_m1   = (mode_reg == lcdw_pkg::MODE_ZERO) ? col_s + wid_s - 8'sd2
                                                          : col_s - 8'sd1;
    assign start_wrap = wrap_cols(start_m1);

    always_comb
    begin
        push_desc.left_align = (mode_reg == lcdw_pkg::MODE_LEFT);
        push_desc.row_ok     = (row_reg >= 3'd1) && (row_reg <= 3'd4);
        push_desc.base       = lcdw_pkg::row_base(2'(row_reg - 3'd1));
        push_desc.off        = start_wrap[lcdw_pkg::OFF_W-1:0];
        push_desc.num_digits = nd_reg;
        push_desc.num_pad    = (mode_reg != lcdw_pkg::MODE_RIGHT &&
                                width_reg > 5'(nd_reg)) ? width_reg - 5'(nd_reg) : 5'd0;
        push_desc.digits     = digits_reg;
    end

    assign push = (state_reg == S_PUSH) && !full;

    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> nd_reg < lcdw_pkg::ND_W'(lcdw_pkg::MAX_DIGITS))
        else $error("digit count overran");
    a_push_digits: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (nd_reg != '0 && nd_reg <= lcdw_pkg::ND_W'(lcdw_pkg::MAX_DIGITS)))
        else $error("descriptor queued with bad digit count");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode_ok) |=> !request.ready)
        else $error("front took a request while extracting");

endmodule

// ----- design/lcdw_queue.sv -----
`timescale 1ns / 1ps
// Descriptor queue between front end and write sequencer.
module lcdw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lcdw_pkg::desc_t push_desc,
    output logic            full,
    input  logic            pop,
    output lcdw_pkg::desc_t head,
    output logic            avail
);

    localparam int DEPTH = lcdw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdw_pkg::desc_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign avail = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> avail)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");

endmodule

// ----- design/lcdw_back.sv -----
`timescale 1ns / 1ps
// Back end: walks a descriptor and issues address commands and characters.
module lcdw_back #(
    parameter int DISPLAY_COLUMNS = lcdw_pkg::DISPLAY_COLUMNS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,
    input  lcdw_pkg::desc_t head,
    output logic            pop,
    lcdw_out_if.source      lcd_wr
);

    localparam logic [lcdw_pkg::OFF_W-1:0] OFF_MAX = lcdw_pkg::OFF_W'(DISPLAY_COLUMNS - 1);

    logic                          active_reg;
    logic [4:0]                    k_reg;
    logic                          addr_phase_reg;
    logic                          out_valid_reg;
    lcdw_pkg::desc_t               desc_reg;
    logic [lcdw_pkg::OFF_W-1:0]    off_reg;
    logic                          rs_reg;
    logic [7:0]                    byte_reg;
    logic                          last_reg;

    logic                          slot_free;
    logic                          step;
    logic [4:0]                    total;
    logic                          is_digit;
    logic                          emit_addr;
    logic                          is_final;
    logic [lcdw_pkg::ND_W-1:0]     dig_idx;
    lcdw_pkg::digit_t              digit;
    logic [7:0]                    ch;
    logic [7:0]                    addr_byte;
    logic [lcdw_pkg::OFF_W-1:0]    off_step;

    assign slot_free = !out_valid_reg || lcd_wr.ready;
    assign step      = active_reg && slot_free;
    assign pop       = !active_reg && avail;

    assign total     = 5'(desc_reg.num_digits) + desc_reg.num_pad;
    assign is_digit  = k_reg < 5'(desc_reg.num_digits);
    assign emit_addr = addr_phase_reg && desc_reg.row_ok && (is_digit || !desc_reg.left_align);
    assign is_final  = !emit_addr && (k_reg == total - 5'd1);

    assign dig_idx   = desc_reg.left_align ?
                       desc_reg.num_digits - 1'b1 - k_reg[lcdw_pkg::ND_W-1:0] :
                       k_reg[lcdw_pkg::ND_W-1:0];
    assign digit     = desc_reg.digits[dig_idx];
    assign ch        = is_digit ? (lcdw_pkg::ZERO_CHAR | {4'b0, digit}) :
                       (desc_reg.left_align ? lcdw_pkg::SPACE_CHAR : lcdw_pkg::ZERO_CHAR);
    assign addr_byte = lcdw_pkg::ADDR_CMD | {1'b0, desc_reg.base + 7'(off_reg)};

    always_comb
    begin
        if (desc_reg.left_align)
            off_step = (off_reg == OFF_MAX) ? '0 : off_reg + 1'b1;
        else
            off_step = (off_reg == '0) ? OFF_MAX : off_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            k_reg          <= '0;
            addr_phase_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                active_reg     <= 1'b1;
                k_reg          <= '0;
                addr_phase_reg <= 1'b1;
            end
            else if (step)
            begin
                if (emit_addr)
                    addr_phase_reg <= 1'b0;
                else
                begin
                    k_reg          <= k_reg + 1'b1;
                    addr_phase_reg <= 1'b1;
                    if (is_final)
                        active_reg <= 1'b0;
                end
            end

            if (step)
                out_valid_reg <= 1'b1;
            else if (lcd_wr.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= head;
            off_reg  <= head.off;
        end
        else if (step && !emit_addr)
            off_reg <= off_step;

        if (step)
        begin
            rs_reg   <= !emit_addr;
            byte_reg <= emit_addr ? addr_byte : ch;
            last_reg <= is_final;
        end
    end

    assign lcd_wr.valid      = out_valid_reg;
    assign lcd_wr.reg_select = rs_reg;
    assign lcd_wr.lcd_byte   = byte_reg;
    assign lcd_wr.last       = last_reg;

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> k_reg < total)
        else $error("character index past end of field");
    a_last_is_char: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> rs_reg)
        else $error("final write is not a character");
    a_cmd_has_msb: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rs_reg) |-> byte_reg[7])
        else $error("instruction byte is not a set-address command");

endmodule

// ----- design/lcd_decimal_field_writer_core.sv -----
`timescale 1ns / 1ps
// Top level of the LCD decimal field writer.
// Front: accepts a request, then per decimal digit a reciprocal multiply step and a remainder step,
//   then queues the descriptor, waiting while the queue is full (D = 1..10 digits); mode 3: no writes.
// Back: 1 LCD write per cycle from a registered output while writing a number and the receiver is
//   ready, 0 to 32 writes per number; the front extracts the next number while the back writes.
// Reset (rst_n low, asynchronous) idles both ends, empties the 2-entry queue, drops pending writes.
module lcd_decimal_field_writer_core #(
    parameter int DISPLAY_COLUMNS = lcdw_pkg::DISPLAY_COLUMNS_DEF,
    parameter int VALUE_BITS      = lcdw_pkg::VALUE_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    lcdw_in_if.sink    request,
    lcdw_out_if.source lcd_wr
);

    logic            push;
    logic            full;
    logic            pop;
    logic            avail;
    lcdw_pkg::desc_t push_desc;
    lcdw_pkg::desc_t head;

    lcdw_front #(
        .VALUE_BITS      (VALUE_BITS),
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .push      (push),
        .push_desc (push_desc),
        .full      (full)
    );

    lcdw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .avail     (avail)
    );

    lcdw_back #(
        .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (avail),
        .head   (head),
        .pop    (pop),
        .lcd_wr (lcd_wr)
    );

endmodule

// ----- tb/sv/tb_lcd_decimal_field_writer_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench: numbers in, LCD write transactions predicted and compared in order.
module tb_lcd_decimal_field_writer_core;
    import lcdw_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         MAX_WRITES  = 32;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         RANDOM_PER_PHASE = 100;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] value;
        logic [4:0]  column;
        logic [2:0]  row;
        logic [4:0]  field_width;
    } num_req_t;

    typedef struct packed {
        logic       reg_select;
        logic [7:0] lcd_byte;
        logic       last;
    } lcd_write_t;

    logic clk;
    logic rst_n;

    lcdw_in_if  request_ch ();
    lcdw_out_if lcd_ch ();

    lcd_decimal_field_writer_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .lcd_wr  (lcd_ch)
    );

    num_req_t   numbers_to_send [$];
    lcd_write_t expected_writes [$];
    lcd_write_t batch [$];
    num_req_t   next_num;
    logic       req_fire;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         mismatches;
    int         cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------ predictor
    function automatic logic [6:0] line_base(input logic [2:0] r);
        logic [6:0] b;
        case (r)
            3'd1:    b = 7'h00;
            3'd2:    b = 7'h40;
            3'd3:    b = 7'h10;
            default: b = 7'h50;
        endcase
        return b;
    endfunction

    function void queue_write(input logic rs, input logic [7:0] b);
        lcd_write_t w;
        if (batch.size() < MAX_WRITES)
        begin
            w.reg_select = rs;
            w.lcd_byte   = b;
            w.last       = 1'b0;
            batch.push_back(w);
        end
    endfunction

    function void place_char(input logic [7:0] ch, input int pos, input logic [2:0] r);
        int         off;
        logic [6:0] addr;
        if (r >= 3'd1 && r <= 3'd4)
        begin
            off = (pos - 1) % DISPLAY_COLUMNS_DEF;
            if (off < 0)
                off += DISPLAY_COLUMNS_DEF;
            addr = line_base(r) + 7'(off);
            queue_write(1'b0, ADDR_CMD | {1'b0, addr});
        end
        queue_write(1'b1, ch);
    endfunction

    function void predict_writes(input num_req_t r);
        int          nd;
        int          pos;
        int          i;
        int          width;
        int          col;
        logic [3:0]  dig [MAX_DIGITS];
        logic [31:0] v;
        lcd_write_t  w;
        batch.delete();
        width = r.field_width;
        if (width > WIDTH_LIMIT)
            width = WIDTH_LIMIT;
        col = r.column;
        v   = r.value;
        nd  = 0;
        while (nd == 0 || (v != 0 && nd < MAX_DIGITS))
        begin
            dig[nd] = 4'(v % 10);
            v = v / 10;
            nd++;
        end
        if (r.mode == MODE_RIGHT || r.mode == MODE_ZERO)
        begin
            pos = (r.mode == MODE_RIGHT) ? col : col + width - 1;
            for (i = 0; i < nd; i++)
            begin
                place_char(ZERO_CHAR + dig[i], pos, r.row);
                pos--;
            end
            if (r.mode == MODE_ZERO)
            begin
                while (pos >= col)
                begin
                    place_char(ZERO_CHAR, pos, r.row);
                    pos--;
                end
            end
        end
        else if (r.mode == MODE_LEFT)
        begin
            pos = col;
            for (i = nd - 1; i >= 0; i--)
            begin
                place_char(ZERO_CHAR + dig[i], pos, r.row);
                pos++;
            end
            while (pos < col + width)
            begin
                queue_write(1'b1, SPACE_CHAR);
                pos++;
            end
        end
        if (batch.size() > 0)
        begin
            w = batch.pop_back();
            w.last = 1'b1;
            batch.push_back(w);
        end
        foreach (batch[k])
            expected_writes.push_back(batch[k]);
    endfunction

    // ------------------------------------------------------------------ stimulus
    function void add_number(input logic [1:0] m, input logic [31:0] val, input logic [4:0] c,
                             input logic [2:0] r, input logic [4:0] fw);
        num_req_t n;
        n.mode        = m;
        n.value       = val;
        n.column      = c;
        n.row         = r;
        n.field_width = fw;
        numbers_to_send.push_back(n);
    endfunction

    function void add_random_number();
        logic [1:0]  m;
        logic [31:0] val;
        logic [31:0] lo;
        int          nd;
        int          i;
        m = ($urandom_range(0, 99) < 6) ? MODE_UNUSED : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 3) == 0)
            val = $urandom;
        else
        begin
            nd = $urandom_range(1, MAX_DIGITS);
            if (nd == MAX_DIGITS)
                val = 32'd1000000000 + $urandom_range(0, 32'd3294967295);
            else
            begin
                lo = 1;
                for (i = 1; i < nd; i++)
                    lo = lo * 10;
                val = $urandom_range((nd == 1) ? 0 : lo, lo * 10 - 1);
            end
        end
        add_number(m, val,
                   ($urandom_range(0, 99) < 85) ? 5'($urandom_range(1, 16)) : 5'($urandom),
                   ($urandom_range(0, 99) < 85) ? 3'($urandom_range(1, 4)) : 3'($urandom),
                   ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 16)) : 5'($urandom));
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int i;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (i = 0; i < RANDOM_PER_PHASE; i++)
            add_random_number();
        @(posedge clk);
        while (numbers_to_send.size() != 0 || request_ch.valid || expected_writes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        request_ch.valid       = 1'b0;
        request_ch.mode        = '0;
        request_ch.value       = '0;
        request_ch.column      = '0;
        request_ch.row         = '0;
        request_ch.field_width = '0;
        lcd_ch.ready           = 1'b0;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        mismatches             = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_number(MODE_RIGHT, 32'd0,          5'd1,  3'd1, 5'd0);
        add_number(MODE_RIGHT, 32'hFFFF_FFFF,  5'd16, 3'd2, 5'd0);
        add_number(MODE_RIGHT, 32'd12345,      5'd3,  3'd3, 5'd0);
        add_number(MODE_RIGHT, 32'd7,          5'd16, 3'd4, 5'd0);
        add_number(MODE_ZERO,  32'd42,         5'd1,  3'd1, 5'd16);
        add_number(MODE_ZERO,  32'hFFFF_FFFF,  5'd1,  3'd4, 5'd16);
        add_number(MODE_ZERO,  32'd123456,     5'd5,  3'd2, 5'd3);
        add_number(MODE_ZERO,  32'd0,          5'd16, 3'd3, 5'd0);
        add_number(MODE_ZERO,  32'd99,         5'd10, 3'd1, 5'd31);
        add_number(MODE_LEFT,  32'd1,          5'd1,  3'd1, 5'd16);
        add_number(MODE_LEFT,  32'd0,          5'd8,  3'd2, 5'd5);
        add_number(MODE_LEFT,  32'hFFFF_FFFF,  5'd16, 3'd3, 5'd16);
        add_number(MODE_LEFT,  32'd98765,      5'd2,  3'd4, 5'd3);
        add_number(MODE_LEFT,  32'd31,         5'd1,  3'd1, 5'd20);
        add_number(MODE_UNUSED, 32'd12345,     5'd5,  3'd1, 5'd5);
        add_number(MODE_UNUSED, 32'd0,         5'd0,  3'd0, 5'd0);
        add_number(MODE_RIGHT, 32'd555,        5'd8,  3'd0, 5'd0);
        add_number(MODE_ZERO,  32'd77,         5'd4,  3'd5, 5'd6);
        add_number(MODE_LEFT,  32'd123,        5'd1,  3'd7, 5'd10);
        add_number(MODE_RIGHT, 32'd10,         5'd0,  3'd1, 5'd0);
        add_number(MODE_ZERO,  32'd1000000000, 5'd31, 3'd2, 5'd17);
        add_number(MODE_LEFT,  32'd9,          5'd31, 3'd3, 5'd31);
        add_number(MODE_RIGHT, 32'h8000_0000,  5'd20, 3'd6, 5'd0);
        add_number(MODE_ZERO,  32'd5,          5'd1,  3'd0, 5'd1);
        add_number(MODE_LEFT,  32'd1,          5'd16, 3'd4, 5'd0);

        run_phase(0, 0);
        run_phase(83, 0);
        run_phase(0, 83);
        run_phase(8, 8);

        repeat (64) @(posedge clk);
        if (expected_writes.size() != 0)
        begin
            $display("%0t: %0d expected lcd writes never arrived", $time, expected_writes.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------ driver
    always @(negedge clk)
    begin
        if (!rst_n)
            request_ch.valid <= 1'b0;
        else if (!request_ch.valid || req_fire)
        begin
            if (numbers_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_num = numbers_to_send.pop_front();
                request_ch.valid       <= 1'b1;
                request_ch.mode        <= next_num.mode;
                request_ch.value       <= next_num.value;
                request_ch.column      <= next_num.column;
                request_ch.row         <= next_num.row;
                request_ch.field_width <= next_num.field_width;
            end
            else
                request_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            lcd_ch.ready <= 1'b0;
        else
            lcd_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------ monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            req_fire <= 1'b0;
        else
        begin
            req_fire <= request_ch.valid && request_ch.ready;
            if (request_ch.valid && request_ch.ready)
                predict_writes({request_ch.mode, request_ch.value, request_ch.column,
                                request_ch.row, request_ch.field_width});
            if (lcd_ch.valid && lcd_ch.ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    $display("%0t: unexpected lcd write: expected none, got rs=%0b byte=%02h last=%0b",
                             $time, lcd_ch.reg_select, lcd_ch.lcd_byte, lcd_ch.last);
                    mismatches++;
                end
                else
                begin
                    if (expected_writes[0].reg_select !== lcd_ch.reg_select
                        || expected_writes[0].lcd_byte !== lcd_ch.lcd_byte
                        || expected_writes[0].last !== lcd_ch.last)
                    begin
                        $display("%0t: lcd write mismatch: expected rs=%0b byte=%02h last=%0b, got rs=%0b byte=%02h last=%0b",
                                 $time, expected_writes[0].reg_select, expected_writes[0].lcd_byte,
                                 expected_writes[0].last, lcd_ch.reg_select, lcd_ch.lcd_byte,
                                 lcd_ch.last);
                        mismatches++;
                    end
                    void'(expected_writes.pop_front());
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
        cycle_count = 0;

endmodule

// ----- lcd_decimal_field_writer_core.f -----
design/lcdw_pkg.sv
design/lcdw_in_if.sv
design/lcdw_out_if.sv
design/lcdw_front.sv
design/lcdw_queue.sv
design/lcdw_back.sv
design/lcd_decimal_field_writer_core.sv
tb/sv/tb_lcd_decimal_field_writer_core.sv
